[hdl/srht_pkg.sv]
package srht_pkg;

	// outcode bit positions
	localparam int CODE_LEFT  = 0;
	localparam int CODE_RIGHT = 1;
	localparam int CODE_BELOW = 2;
	localparam int CODE_ABOVE = 3;

	typedef enum logic [1:0] {
		REG_LEFT   = 2'd0,
		REG_BOTTOM = 2'd1,
		REG_RIGHT  = 2'd2,
		REG_TOP    = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		DEC_INSIDE   = 3'd0,
		DEC_SHARED   = 3'd1,
		DEC_AXIS     = 3'd2,
		DEC_CROSSING = 3'd3,
		DEC_NONE     = 3'd4
	} decide_t;

	// per-stage load enables
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
		logic en_s5;
	} pipe_en_t;

	// segment facts that ride along with the products
	typedef struct packed {
		logic [3:0] start_code;
		logic [3:0] end_code;
		logic       x_eq;
		logic       y_eq;
	} meta_t;

endpackage

[hdl/srht_front.sv]
module srht_front #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  srht_pkg::pipe_en_t           en,
	input  logic signed [COORD_BITS-1:0] rect_left,
	input  logic signed [COORD_BITS-1:0] rect_bottom,
	input  logic signed [COORD_BITS-1:0] rect_right,
	input  logic signed [COORD_BITS-1:0] rect_top,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output srht_pkg::meta_t              meta_s2,
	output logic signed [COORD_BITS:0]   sx_s2,
	output logic signed [COORD_BITS:0]   sy_s2,
	output logic signed [COORD_BITS:0]   ty_s2,
	output logic signed [COORD_BITS:0]   tx_s2,
	output logic signed [COORD_BITS:0]   db_s2,
	output logic signed [COORD_BITS:0]   dt_s2,
	output logic signed [COORD_BITS:0]   dl_s2,
	output logic signed [COORD_BITS:0]   dr_s2
);
	import srht_pkg::*;

	localparam int OP_BITS = COORD_BITS + 1;

	function automatic logic [3:0] outcode(
		input logic signed [COORD_BITS-1:0] x,
		input logic signed [COORD_BITS-1:0] y,
		input logic signed [COORD_BITS-1:0] l,
		input logic signed [COORD_BITS-1:0] b,
		input logic signed [COORD_BITS-1:0] r,
		input logic signed [COORD_BITS-1:0] t
	);
		logic [3:0] c;
		c = 4'b0000;
		if (x < l) begin
			c[CODE_LEFT] = 1'b1;
		end else if (x > r) begin
			c[CODE_RIGHT] = 1'b1;
		end
		if (y < b) begin
			c[CODE_BELOW] = 1'b1;
		end else if (y > t) begin
			c[CODE_ABOVE] = 1'b1;
		end
		return c;
	endfunction

	logic signed [OP_BITS-1:0] x1_e, y1_e, x2_e, y2_e;
	logic signed [OP_BITS-1:0] l_e, b_e, r_e, t_e;

	meta_t                     meta_s1;
	logic signed [OP_BITS-1:0] dx_s1, dy_s1, db_s1, dt_s1, dl_s1, dr_s1;

	assign x1_e = {start_x[COORD_BITS-1], start_x};
	assign y1_e = {start_y[COORD_BITS-1], start_y};
	assign x2_e = {end_x[COORD_BITS-1], end_x};
	assign y2_e = {end_y[COORD_BITS-1], end_y};
	assign l_e  = {rect_left[COORD_BITS-1], rect_left};
	assign b_e  = {rect_bottom[COORD_BITS-1], rect_bottom};
	assign r_e  = {rect_right[COORD_BITS-1], rect_right};
	assign t_e  = {rect_top[COORD_BITS-1], rect_top};

	always_ff @(posedge clk) begin
		if (en.en_s1) begin
			meta_s1.start_code <= outcode(start_x, start_y, rect_left, rect_bottom,
				rect_right, rect_top);
			meta_s1.end_code   <= outcode(end_x, end_y, rect_left, rect_bottom,
				rect_right, rect_top);
			meta_s1.x_eq       <= (start_x == end_x);
			meta_s1.y_eq       <= (start_y == end_y);
			dx_s1 <= x1_e - x2_e;
			dy_s1 <= y1_e - y2_e;
			db_s1 <= b_e - y1_e;
			dt_s1 <= t_e - y1_e;
			dl_s1 <= l_e - x1_e;
			dr_s1 <= r_e - x1_e;
		end
	end

	// orient the direction: +x step for vertical edges, +y step for horizontal
	always_ff @(posedge clk) begin
		if (en.en_s2) begin
			meta_s2 <= meta_s1;
			sx_s2   <= dx_s1[OP_BITS-1] ? -dx_s1 : dx_s1;
			sy_s2   <= dx_s1[OP_BITS-1] ? -dy_s1 : dy_s1;
			ty_s2   <= dy_s1[OP_BITS-1] ? -dy_s1 : dy_s1;
			tx_s2   <= dy_s1[OP_BITS-1] ? -dx_s1 : dx_s1;
			db_s2   <= db_s1;
			dt_s2   <= dt_s1;
			dl_s2   <= dl_s1;
			dr_s2   <= dr_s1;
		end
	end

endmodule

[hdl/srht_wmul.sv]
module srht_wmul #(
	parameter int OP_BITS = 25
) (
	input  logic                          clk,
	input  srht_pkg::pipe_en_t            en,
	input  logic signed [OP_BITS-1:0]     a,
	input  logic signed [OP_BITS-1:0]     b,
	output logic signed [2*OP_BITS-1:0]   prod_s4
);
	import srht_pkg::*;

	localparam int LO = (OP_BITS + 1) / 2;
	localparam int HI = OP_BITS - LO;
	localparam int PW = 2 * OP_BITS;

	logic        [LO-1:0]    a_lo, b_lo;
	logic signed [LO:0]      a_lo_s, b_lo_s;
	logic signed [HI-1:0]    a_hi, b_hi;

	logic signed [2*HI-1:0]  hh_s3;
	logic signed [HI+LO:0]   hl_s3, lh_s3;
	logic        [2*LO-1:0]  ll_s3;

	logic signed [PW-1:0]    hh_x, hl_x, lh_x, ll_x, cross_sum;

	// signed high half, unsigned low half
	assign a_lo   = a[LO-1:0];
	assign b_lo   = b[LO-1:0];
	assign a_hi   = a[OP_BITS-1:LO];
	assign b_hi   = b[OP_BITS-1:LO];
	assign a_lo_s = {1'b0, a_lo};
	assign b_lo_s = {1'b0, b_lo};

	always_ff @(posedge clk) begin
		if (en.en_s3) begin
			hh_s3 <= a_hi * b_hi;
			hl_s3 <= a_hi * b_lo_s;
			lh_s3 <= a_lo_s * b_hi;
			ll_s3 <= a_lo * b_lo;
		end
	end

	assign hh_x      = {{(PW-2*HI){hh_s3[2*HI-1]}}, hh_s3};
	assign hl_x      = {{(PW-HI-LO-1){hl_s3[HI+LO]}}, hl_s3};
	assign lh_x      = {{(PW-HI-LO-1){lh_s3[HI+LO]}}, lh_s3};
	assign ll_x      = {{(PW-2*LO){1'b0}}, ll_s3};
	assign cross_sum = hl_x + lh_x;

	always_ff @(posedge clk) begin
		if (en.en_s4) begin
			prod_s4 <= (hh_x <<< (2 * LO)) + (cross_sum <<< LO) + ll_x;
		end
	end

endmodule

[hdl/srht_decide.sv]
module srht_decide #(
	parameter int OP_BITS = 25
) (
	input  logic                        clk,
	input  srht_pkg::pipe_en_t          en,
	input  srht_pkg::meta_t             meta_s4,
	input  logic signed [2*OP_BITS-1:0] lo_v,
	input  logic signed [2*OP_BITS-1:0] hi_v,
	input  logic signed [2*OP_BITS-1:0] mid_l,
	input  logic signed [2*OP_BITS-1:0] mid_r,
	input  logic signed [2*OP_BITS-1:0] lo_h,
	input  logic signed [2*OP_BITS-1:0] hi_h,
	input  logic signed [2*OP_BITS-1:0] mid_t,
	input  logic signed [2*OP_BITS-1:0] mid_b,
	output logic                        hit_s5,
	output logic [3:0]                  start_code_s5,
	output logic [3:0]                  end_code_s5,
	output logic [2:0]                  decided_by_s5
);
	import srht_pkg::*;

	logic    cross_any;
	logic    hit_d;
	decide_t why_d;

	// crossing with an edge line lies within the inclusive span of the other axis
	assign cross_any = ((lo_v <= mid_l) && (mid_l <= hi_v))
		|| ((lo_v <= mid_r) && (mid_r <= hi_v))
		|| ((lo_h <= mid_t) && (mid_t <= hi_h))
		|| ((lo_h <= mid_b) && (mid_b <= hi_h));

	always_comb begin
		priority if ((meta_s4.start_code == 4'b0000) || (meta_s4.end_code == 4'b0000)) begin
			hit_d = 1'b1;
			why_d = DEC_INSIDE;
		end else if ((meta_s4.start_code & meta_s4.end_code) != 4'b0000) begin
			hit_d = 1'b0;
			why_d = DEC_SHARED;
		end else if (meta_s4.x_eq || meta_s4.y_eq) begin
			hit_d = 1'b1;
			why_d = DEC_AXIS;
		end else if (cross_any) begin
			hit_d = 1'b1;
			why_d = DEC_CROSSING;
		end else begin
			hit_d = 1'b0;
			why_d = DEC_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s5) begin
			hit_s5        <= hit_d;
			start_code_s5 <= meta_s4.start_code;
			end_code_s5   <= meta_s4.end_code;
			decided_by_s5 <= why_d;
		end
	end

endmodule

[hdl/segment_rectangle_hit_test.sv]
// Segment versus rectangle hit test. Each beat on the seg channel carries one
// segment (two endpoints, signed Q8.16); each beat on the res channel carries
// the hit flag, both endpoint outcodes and the rule that decided. The rectangle
// is set through the cfg write port (0 left, 1 bottom, 2 right, 3 top, reset 0)
// and must only be written while no segment is in flight. One segment per
// clock is accepted while the res channel is not stalled. The five-stage
// pipeline: outcodes and differences, direction fix-up, split partial
// products, product sum, compare and decision. Bubbles are squeezed out, so
// input is taken while a result waits in the output register if a stage is free.
module segment_rectangle_hit_test #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [1:0]                   cfg_index,
	input  logic [COORD_BITS-1:0]        cfg_data,
	input  logic                         seg_valid,
	output logic                         seg_stall,
	input  logic signed [COORD_BITS-1:0] start_x,
	input  logic signed [COORD_BITS-1:0] start_y,
	input  logic signed [COORD_BITS-1:0] end_x,
	input  logic signed [COORD_BITS-1:0] end_y,
	output logic                         res_valid,
	input  logic                         res_stall,
	output logic                         hit,
	output logic [3:0]                   start_code,
	output logic [3:0]                   end_code,
	output logic [2:0]                   decided_by
);
	import srht_pkg::*;

	localparam int OP_BITS = COORD_BITS + 1;
	localparam int PW      = 2 * OP_BITS;

	logic signed [COORD_BITS-1:0] rect_left_q, rect_bottom_q, rect_right_q, rect_top_q;

	logic     v_s1, v_s2, v_s3, v_s4, v_s5;
	logic     rdy1, rdy2, rdy3, rdy4, rdy5;
	pipe_en_t en;

	meta_t                     meta_s2, meta_s3, meta_s4;
	logic signed [OP_BITS-1:0] sx_s2, sy_s2, ty_s2, tx_s2, db_s2, dt_s2, dl_s2, dr_s2;
	logic signed [PW-1:0]      lo_v, hi_v, mid_l, mid_r, lo_h, hi_h, mid_t, mid_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rect_left_q   <= '0;
			rect_bottom_q <= '0;
			rect_right_q  <= '0;
			rect_top_q    <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_LEFT:   rect_left_q   <= cfg_data;
				REG_BOTTOM: rect_bottom_q <= cfg_data;
				REG_RIGHT:  rect_right_q  <= cfg_data;
				REG_TOP:    rect_top_q    <= cfg_data;
				default:    ;
			endcase
		end
	end

	// a stage loads when it is empty or the next one is taking its beat
	assign rdy5 = !v_s5 || !res_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign en.en_s1 = rdy1;
	assign en.en_s2 = rdy2;
	assign en.en_s3 = rdy3;
	assign en.en_s4 = rdy4;
	assign en.en_s5 = rdy5;

	assign seg_stall = !rdy1;
	assign res_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= seg_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en.en_s3) meta_s3 <= meta_s2;
		if (en.en_s4) meta_s4 <= meta_s3;
	end

	srht_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.en         (en),
		.rect_left  (rect_left_q),
		.rect_bottom(rect_bottom_q),
		.rect_right (rect_right_q),
		.rect_top   (rect_top_q),
		.start_x    (start_x),
		.start_y    (start_y),
		.end_x      (end_x),
		.end_y      (end_y),
		.meta_s2    (meta_s2),
		.sx_s2      (sx_s2),
		.sy_s2      (sy_s2),
		.ty_s2      (ty_s2),
		.tx_s2      (tx_s2),
		.db_s2      (db_s2),
		.dt_s2      (dt_s2),
		.dl_s2      (dl_s2),
		.dr_s2      (dr_s2)
	);

	// vertical edges
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_lo_v  (.clk(clk), .en(en), .a(sx_s2), .b(db_s2),
		.prod_s4(lo_v));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_hi_v  (.clk(clk), .en(en), .a(sx_s2), .b(dt_s2),
		.prod_s4(hi_v));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_mid_l (.clk(clk), .en(en), .a(sy_s2), .b(dl_s2),
		.prod_s4(mid_l));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_mid_r (.clk(clk), .en(en), .a(sy_s2), .b(dr_s2),
		.prod_s4(mid_r));
	// horizontal edges
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_lo_h  (.clk(clk), .en(en), .a(ty_s2), .b(dl_s2),
		.prod_s4(lo_h));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_hi_h  (.clk(clk), .en(en), .a(ty_s2), .b(dr_s2),
		.prod_s4(hi_h));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_mid_t (.clk(clk), .en(en), .a(tx_s2), .b(dt_s2),
		.prod_s4(mid_t));
	srht_wmul #(.OP_BITS(OP_BITS)) u_mul_mid_b (.clk(clk), .en(en), .a(tx_s2), .b(db_s2),
		.prod_s4(mid_b));

	srht_decide #(.OP_BITS(OP_BITS)) u_decide (
		.clk          (clk),
		.en           (en),
		.meta_s4      (meta_s4),
		.lo_v         (lo_v),
		.hi_v         (hi_v),
		.mid_l        (mid_l),
		.mid_r        (mid_r),
		.lo_h         (lo_h),
		.hi_h         (hi_h),
		.mid_t        (mid_t),
		.mid_b        (mid_b),
		.hit_s5       (hit),
		.start_code_s5(start_code),
		.end_code_s5  (end_code),
		.decided_by_s5(decided_by)
	);

endmodule
